/* rtl/fte_pkg.sv */
// ----------------------------------------------------------------------------
// fte_pkg
// shared types and codes of the flow table match engine
// ----------------------------------------------------------------------------
package fte_pkg;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_MODIFY = 2'd1,
        OP_DELETE = 2'd2,
        OP_HIT    = 2'd3
    } fte_op_t;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_MISS = 2'd2;

    typedef struct packed {
        fte_op_t     op;
        logic [31:0] flow_id;
        logic [31:0] port_pair;
        logic [7:0]  action;
    } fte_req_t;

    typedef struct packed {
        logic valid;
        logic found;
        logic before_ok;
        logic after_ok;
    } fte_flags_t;

endpackage

/* rtl/fte_cell.sv */
// ----------------------------------------------------------------------------
// fte_cell
// one table entry; acts on the request passing through and hands it on
// ----------------------------------------------------------------------------
module fte_cell #(
    parameter int IDX_W  = 6,
    parameter int SLOT_W = 7,
    parameter int INDEX  = 0
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  fte_pkg::fte_req_t   req_i,
    input  fte_pkg::fte_flags_t flags_i,
    input  logic [SLOT_W-1:0]  target_i,
    input  logic [IDX_W-1:0]   match_i,
    input  logic [7:0]         act_i,
    input  logic [IDX_W-1:0]   before_i,
    input  logic [IDX_W-1:0]   after_i,
    output fte_pkg::fte_req_t   req_o,
    output fte_pkg::fte_flags_t flags_o,
    output logic [SLOT_W-1:0]  target_o,
    output logic [IDX_W-1:0]   match_o,
    output logic [7:0]         act_o,
    output logic [IDX_W-1:0]   before_o,
    output logic [IDX_W-1:0]   after_o
);
    import fte_pkg::*;

    localparam logic [IDX_W-1:0]  CELL_IDX  = IDX_W'(INDEX);
    localparam logic [SLOT_W-1:0] CELL_SLOT = SLOT_W'(INDEX);

    logic        valid_reg;
    logic [31:0] id_reg;
    logic [31:0] key_reg;
    logic [7:0]  action_reg;

    fte_req_t          req_reg;
    fte_flags_t        flags_reg;
    logic [SLOT_W-1:0] target_reg;
    logic [IDX_W-1:0]  match_reg;
    logic [7:0]        act_reg;
    logic [IDX_W-1:0]  before_reg;
    logic [IDX_W-1:0]  after_reg;

    logic       fire;
    logic       id_hit;
    logic       key_hit;
    logic       take;
    logic       add_here;
    logic       is_free;
    logic       below;
    fte_flags_t flags_next;

    assign fire     = flags_i.valid && adv;
    assign id_hit   = valid_reg && (id_reg == req_i.flow_id);
    assign key_hit  = valid_reg && (key_reg == req_i.port_pair);
    assign add_here = (req_i.op == OP_ADD) && (target_i == CELL_SLOT);
    assign is_free  = !valid_reg && !add_here;
    assign below    = CELL_SLOT < target_i;

    always_comb
    begin
        unique case (req_i.op)
            OP_MODIFY, OP_DELETE: take = !flags_i.found && id_hit;
            OP_HIT:               take = !flags_i.found && key_hit;
            default:              take = 1'b0;
        endcase
    end

    always_comb
    begin
        flags_next           = flags_i;
        flags_next.found     = flags_i.found || take;
        flags_next.before_ok = flags_i.before_ok || (is_free && below);
        flags_next.after_ok  = flags_i.after_ok || (is_free && !below);
    end

    // entry storage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            if (add_here)
            begin
                valid_reg <= 1'b1;
            end
            else if (take && (req_i.op == OP_DELETE))
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && add_here)
        begin
            id_reg     <= req_i.flow_id;
            key_reg    <= req_i.port_pair;
            action_reg <= req_i.action;
        end
        else if (fire && take && (req_i.op == OP_MODIFY))
        begin
            action_reg <= req_i.action;
        end
    end

    // hand-off to the next cell
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
        end
        else if (adv)
        begin
            flags_reg <= flags_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            req_reg    <= req_i;
            target_reg <= target_i;
            match_reg  <= take ? CELL_IDX : match_i;
            act_reg    <= take ? action_reg : act_i;
            before_reg <= (!flags_i.before_ok && is_free && below) ? CELL_IDX : before_i;
            after_reg  <= (!flags_i.after_ok && is_free && !below) ? CELL_IDX : after_i;
        end
    end

    assign req_o    = req_reg;
    assign flags_o  = flags_reg;
    assign target_o = target_reg;
    assign match_o  = match_reg;
    assign act_o    = act_reg;
    assign before_o = before_reg;
    assign after_o  = after_reg;

endmodule

/* rtl/flow_table_match_engine.sv */
// ----------------------------------------------------------------------------
// flow_table_match_engine
// exact-match flow table held in a chain of entry cells
// ----------------------------------------------------------------------------
//  channel  signals                                   direction
//  request  req_valid req_stall op flow_id             in (stall out)
//           port_pair action_state
//  result   rsp_valid rsp_stall status slot hit_action out (stall in)
//
//  a request walks the cell chain one entry per cycle unless the chain is held;
//  there is one request in flight at a time
//  req_stall is high from acceptance until the result is registered, so
//  a new request is accepted only once the previous result is registered
//  a stalled result holds the whole chain once the next request reaches its tail
//  reset clears all entry valid bits at once; next free slot returns to zero
// ----------------------------------------------------------------------------
module flow_table_match_engine #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  req_valid,
    output logic                                  req_stall,
    input  logic [1:0]                            op,
    input  logic [31:0]                           flow_id,
    input  logic [31:0]                           port_pair,
    input  logic [7:0]                            action_state,
    output logic                                  rsp_valid,
    input  logic                                  rsp_stall,
    output logic [1:0]                            status,
    output logic [$clog2(TABLE_ENTRIES + 1)-1:0] slot,
    output logic [7:0]                            hit_action
);
    import fte_pkg::*;

    localparam int IDX_W  = $clog2(TABLE_ENTRIES);
    localparam int SLOT_W = $clog2(TABLE_ENTRIES + 1);

    localparam logic [SLOT_W-1:0] TABLE_SLOT = SLOT_W'(TABLE_ENTRIES);

    fte_req_t          req_c    [0:TABLE_ENTRIES];
    fte_flags_t        flags_c  [0:TABLE_ENTRIES];
    logic [SLOT_W-1:0] target_c [0:TABLE_ENTRIES];
    logic [IDX_W-1:0]  match_c  [0:TABLE_ENTRIES];
    logic [7:0]        act_c    [0:TABLE_ENTRIES];
    logic [IDX_W-1:0]  before_c [0:TABLE_ENTRIES];
    logic [IDX_W-1:0]  after_c  [0:TABLE_ENTRIES];

    fte_req_t          head_req_reg;
    logic              head_valid_reg;
    logic [SLOT_W-1:0] next_free_reg;
    logic [SLOT_W-1:0] next_free_next;
    logic              busy_reg;
    logic              rsp_valid_reg;
    logic [1:0]        status_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [7:0]        hit_action_reg;

    logic              accept;
    logic              adv;
    logic              tail_fire;
    fte_req_t          tail_req;
    fte_flags_t        tail_flags;
    logic [1:0]        status_next;
    logic [SLOT_W-1:0] slot_next;
    logic [7:0]        hit_action_next;

    assign accept    = req_valid && !req_stall;
    assign req_stall = busy_reg;
    assign tail_req   = req_c[TABLE_ENTRIES];
    assign tail_flags = flags_c[TABLE_ENTRIES];
    assign adv       = !(tail_flags.valid && rsp_valid_reg && rsp_stall);
    assign tail_fire = tail_flags.valid && adv;

    // chain head
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            head_valid_reg <= 1'b1;
        end
        else if (adv)
        begin
            head_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            head_req_reg.op        <= fte_op_t'(op);
            head_req_reg.flow_id   <= flow_id;
            head_req_reg.port_pair <= port_pair;
            head_req_reg.action    <= action_state;
        end
    end

    assign req_c[0]    = head_req_reg;
    assign flags_c[0]  = '{valid: head_valid_reg, found: 1'b0,
                           before_ok: 1'b0, after_ok: 1'b0};
    assign target_c[0] = next_free_reg;
    assign match_c[0]  = '0;
    assign act_c[0]    = '0;
    assign before_c[0] = '0;
    assign after_c[0]  = '0;

    for (genvar i = 0; i < TABLE_ENTRIES; i++)
    begin : g_cell
        fte_cell #(
            .IDX_W  (IDX_W),
            .SLOT_W (SLOT_W),
            .INDEX  (i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .adv      (adv),
            .req_i    (req_c[i]),
            .flags_i  (flags_c[i]),
            .target_i (target_c[i]),
            .match_i  (match_c[i]),
            .act_i    (act_c[i]),
            .before_i (before_c[i]),
            .after_i  (after_c[i]),
            .req_o    (req_c[i+1]),
            .flags_o  (flags_c[i+1]),
            .target_o (target_c[i+1]),
            .match_o  (match_c[i+1]),
            .act_o    (act_c[i+1]),
            .before_o (before_c[i+1]),
            .after_o  (after_c[i+1])
        );
    end

    // result and next free slot at the chain tail
    always_comb
    begin
        status_next     = ST_MISS;
        slot_next       = TABLE_SLOT;
        hit_action_next = '0;
        next_free_next  = next_free_reg;
        unique case (tail_req.op)
            OP_ADD:
            begin
                if (target_c[TABLE_ENTRIES] == TABLE_SLOT)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    status_next = ST_DONE;
                    slot_next   = target_c[TABLE_ENTRIES];
                    if (tail_flags.after_ok)
                    begin
                        next_free_next = SLOT_W'(after_c[TABLE_ENTRIES]);
                    end
                    else if (tail_flags.before_ok)
                    begin
                        next_free_next = SLOT_W'(before_c[TABLE_ENTRIES]);
                    end
                    else
                    begin
                        next_free_next = TABLE_SLOT;
                    end
                end
            end
            OP_MODIFY, OP_DELETE:
            begin
                if (tail_flags.found)
                begin
                    status_next = ST_DONE;
                    slot_next   = SLOT_W'(match_c[TABLE_ENTRIES]);
                    if ((tail_req.op == OP_DELETE) && (next_free_reg == TABLE_SLOT))
                    begin
                        next_free_next = SLOT_W'(match_c[TABLE_ENTRIES]);
                    end
                end
            end
            OP_HIT:
            begin
                if (tail_flags.found)
                begin
                    status_next     = ST_DONE;
                    slot_next       = SLOT_W'(match_c[TABLE_ENTRIES]);
                    hit_action_next = act_c[TABLE_ENTRIES];
                end
            end
            default:
            begin
                status_next = ST_MISS;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_free_reg <= '0;
            busy_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (tail_fire)
            begin
                next_free_reg <= next_free_next;
            end
            if (accept)
            begin
                busy_reg <= 1'b1;
            end
            else if (tail_fire)
            begin
                busy_reg <= 1'b0;
            end
            if (tail_fire)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tail_fire)
        begin
            status_reg     <= status_next;
            slot_reg       <= slot_next;
            hit_action_reg <= hit_action_next;
        end
    end

    assign rsp_valid  = rsp_valid_reg;
    assign status     = status_reg;
    assign slot       = slot_reg;
    assign hit_action = hit_action_reg;

`ifndef SYNTHESIS
    a_next_free_range: assert property (@(posedge clk) disable iff (!rst_n)
        next_free_reg <= TABLE_SLOT)
        else $error("next free slot beyond table");

    a_tail_only_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        tail_flags.valid |-> busy_reg)
        else $error("request at chain tail while idle");

    a_head_only_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid_reg |-> (busy_reg && !tail_flags.valid))
        else $error("chain head loaded out of turn");

    a_release_after_result: assert property (@(posedge clk) disable iff (!rst_n)
        tail_fire |=> (!busy_reg && rsp_valid_reg))
        else $error("request port not released after result");

    a_full_reports_none: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && (status_reg != ST_DONE)) |->
            ((slot_reg == TABLE_SLOT) && (hit_action_reg == 8'd0)))
        else $error("failed request reports a slot");
`endif

endmodule

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the flow table match engine
//
// Requests are queued by the stimulus process and offered by a clocked
// driver. Each accepted request is applied to a shadow flow table, and the
// expected outcome is queued. A clocked monitor compares every accepted
// result with the oldest expected outcome, field by field.
//
// The run starts with a short directed set: empty-table misses, absent ids,
// all-zero and all-one fields, duplicate ids and keys. Random segments
// follow. They fill the table past full, delete while it is full, drain
// it, mix all operations and add noise. Segments cycle through four idle
// patterns on the request side and on the result side. One segment opens
// with a long result hold-off.
// ----------------------------------------------------------------------------
module tb_top;
    import fte_pkg::*;

    localparam int TABLE_ENTRIES  = 64;
    localparam int SLOT_W         = $clog2(TABLE_ENTRIES + 1);
    localparam int POOL_DEPTH     = 128;
    localparam int RAND_PER_SEG   = 175;
    localparam int NUM_SEGS       = 8;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int MAX_REPORTS    = 200;

    typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BAL, MIX_NOISE} mix_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [SLOT_W-1:0] slot;
        logic [7:0]        hit_action;
    } table_outcome_t;

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              req_valid    = 1'b0;
    logic              req_stall;
    logic [1:0]        op           = OP_ADD;
    logic [31:0]       flow_id      = '0;
    logic [31:0]       port_pair    = '0;
    logic [7:0]        action_state = '0;
    logic              rsp_valid;
    logic              rsp_stall    = 1'b0;
    logic [1:0]        status;
    logic [SLOT_W-1:0] slot;
    logic [7:0]        hit_action;

    fte_req_t       request_q [$];
    table_outcome_t outcome_q [$];
    fte_req_t       offered;
    table_outcome_t want_rsp;

    // shadow flow table
    bit          tbl_valid  [TABLE_ENTRIES];
    logic [31:0] tbl_id     [TABLE_ENTRIES];
    logic [31:0] tbl_key    [TABLE_ENTRIES];
    logic [7:0]  tbl_action [TABLE_ENTRIES];
    int          used_cnt = 0;
    int          free_idx = 0;

    // recently added ids and keys, so that lookups mostly hit
    logic [31:0] id_pool  [POOL_DEPTH];
    logic [31:0] key_pool [POOL_DEPTH];
    int          pool_wr   = 0;
    int          pool_fill = 0;

    mix_t seg_mix [NUM_SEGS] = '{MIX_FILL, MIX_BAL, MIX_FILL, MIX_DRAIN,
                                 MIX_BAL, MIX_NOISE, MIX_FILL, MIX_DRAIN};

    int tx_idle_pct   = 0;
    int rx_stall_pct  = 0;
    int holdoff_left  = 0;
    bit holdoff_arm   = 1'b0;
    int accepted_cnt  = 0;
    int results_seen  = 0;
    int err_count     = 0;
    int done_cnt      = 0;
    int full_cnt      = 0;
    int miss_cnt      = 0;

    flow_table_match_engine #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .op           (op),
        .flow_id      (flow_id),
        .port_pair    (port_pair),
        .action_state (action_state),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .status       (status),
        .slot         (slot),
        .hit_action   (hit_action)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int lowest_match(input bit by_key, input logic [31:0] val);
        int hit_idx;
        hit_idx = TABLE_ENTRIES;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
        begin
            if (tbl_valid[i] && ((by_key ? tbl_key[i] : tbl_id[i]) == val))
                hit_idx = i;
        end
        return hit_idx;
    endfunction

    function automatic table_outcome_t table_update(input fte_req_t rq);
        table_outcome_t res;
        int             pos;
        int             p;
        res.status     = ST_MISS;
        res.slot       = SLOT_W'(TABLE_ENTRIES);
        res.hit_action = '0;
        case (rq.op)
            OP_ADD:
            begin
                if (free_idx >= TABLE_ENTRIES)
                begin
                    res.status = ST_FULL;
                end
                else
                begin
                    pos             = free_idx;
                    tbl_valid[pos]  = 1'b1;
                    tbl_id[pos]     = rq.flow_id;
                    tbl_key[pos]    = rq.port_pair;
                    tbl_action[pos] = rq.action;
                    used_cnt++;
                    free_idx = TABLE_ENTRIES;
                    // circular search for the nearest free slot after pos
                    if (used_cnt < TABLE_ENTRIES)
                    begin
                        for (int n = TABLE_ENTRIES - 1; n >= 1; n--)
                        begin
                            p = (pos + n) % TABLE_ENTRIES;
                            if (!tbl_valid[p])
                                free_idx = p;
                        end
                    end
                    res.status = ST_DONE;
                    res.slot   = SLOT_W'(pos);
                end
            end
            OP_MODIFY:
            begin
                pos = lowest_match(1'b0, rq.flow_id);
                if (pos < TABLE_ENTRIES)
                begin
                    tbl_action[pos] = rq.action;
                    res.status      = ST_DONE;
                    res.slot        = SLOT_W'(pos);
                end
            end
            OP_DELETE:
            begin
                pos = lowest_match(1'b0, rq.flow_id);
                if (pos < TABLE_ENTRIES)
                begin
                    tbl_valid[pos] = 1'b0;
                    if (used_cnt > 0)
                        used_cnt--;
                    if (free_idx >= TABLE_ENTRIES)
                        free_idx = pos;
                    res.status = ST_DONE;
                    res.slot   = SLOT_W'(pos);
                end
            end
            default:
            begin
                pos = lowest_match(1'b1, rq.port_pair);
                if (pos < TABLE_ENTRIES)
                begin
                    res.status     = ST_DONE;
                    res.slot       = SLOT_W'(pos);
                    res.hit_action = tbl_action[pos];
                end
            end
        endcase
        return res;
    endfunction

    function automatic int recent_pool_idx();
        int span;
        span = (pool_fill < TABLE_ENTRIES) ? pool_fill : TABLE_ENTRIES;
        return (pool_wr + POOL_DEPTH - 1 - int'($urandom_range(0, span - 1))) % POOL_DEPTH;
    endfunction

    function automatic fte_req_t make_request(input mix_t mix);
        fte_req_t rq;
        int       r;
        int       add_pct;
        int       mod_pct;
        int       del_pct;
        case (mix)
            MIX_FILL:  begin add_pct = 80; mod_pct = 7;  del_pct = 5;  end
            MIX_DRAIN: begin add_pct = 15; mod_pct = 15; del_pct = 45; end
            default:   begin add_pct = 30; mod_pct = 20; del_pct = 20; end
        endcase
        r         = $urandom_range(0, 99);
        rq.action = 8'($urandom_range(0, 255));
        if (r < add_pct)
            rq.op = OP_ADD;
        else if (r < add_pct + mod_pct)
            rq.op = OP_MODIFY;
        else if (r < add_pct + mod_pct + del_pct)
            rq.op = OP_DELETE;
        else
            rq.op = OP_HIT;
        rq.flow_id   = $urandom;
        rq.port_pair = $urandom;
        if (mix == MIX_NOISE)
            rq.op = fte_op_t'($urandom_range(0, 3));
        else if (rq.op == OP_ADD)
        begin
            if (pool_fill != 0 && $urandom_range(0, 9) == 0)
                rq.flow_id = id_pool[recent_pool_idx()];
            if (pool_fill != 0 && $urandom_range(0, 6) == 0)
                rq.port_pair = key_pool[recent_pool_idx()];
            id_pool[pool_wr]  = rq.flow_id;
            key_pool[pool_wr] = rq.port_pair;
            pool_wr = (pool_wr + 1) % POOL_DEPTH;
            if (pool_fill < POOL_DEPTH)
                pool_fill++;
        end
        else if (rq.op == OP_HIT)
        begin
            if (pool_fill != 0 && $urandom_range(0, 99) < 85)
                rq.port_pair = key_pool[recent_pool_idx()];
        end
        else if (pool_fill != 0 && $urandom_range(0, 9) != 0)
            rq.flow_id = id_pool[recent_pool_idx()];
        return rq;
    endfunction

    task automatic queue_request(input fte_op_t o, input logic [31:0] id,
                                 input logic [31:0] key, input logic [7:0] act);
        fte_req_t rq;
        rq.op        = o;
        rq.flow_id   = id;
        rq.port_pair = key;
        rq.action    = act;
        request_q.push_back(rq);
    endtask

    task automatic flag_mismatch(input string msg);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("mismatch on result %0d: %s", results_seen, msg);
    endtask

    // sender pauses here until every request is accepted and answered
    task automatic wait_quiet();
        do
            @(negedge clk);
        while (request_q.size() != 0 || req_valid || outcome_q.size() != 0);
    endtask

    task automatic set_idle(input int tx, input int rx);
        tx_idle_pct  = tx;
        rx_stall_pct = rx;
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid    <= 1'b0;
            op           <= OP_ADD;
            flow_id      <= '0;
            port_pair    <= '0;
            action_state <= '0;
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                outcome_q.push_back(table_update(offered));
                accepted_cnt++;
            end
            if (!req_valid || !req_stall)
            begin
                if (request_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct)
                begin
                    offered       = request_q.pop_front();
                    req_valid    <= 1'b1;
                    op           <= offered.op;
                    flow_id      <= offered.flow_id;
                    port_pair    <= offered.port_pair;
                    action_state <= offered.action;
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // long result hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            holdoff_left <= 0;
        else if (holdoff_left != 0)
            holdoff_left <= holdoff_left - 1;
        else if (holdoff_arm)
            holdoff_left <= HOLDOFF_CYCLES;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_stall <= 1'b0;
        else
            rsp_stall <= (holdoff_left != 0) || ($urandom_range(0, 99) < rx_stall_pct);
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            results_seen++;
            if (outcome_q.size() == 0)
            begin
                flag_mismatch($sformatf("unexpected result status %0d slot %0d action %0h",
                                        status, slot, hit_action));
            end
            else
            begin
                want_rsp = outcome_q.pop_front();
                case (want_rsp.status)
                    ST_DONE: done_cnt++;
                    ST_FULL: full_cnt++;
                    default: miss_cnt++;
                endcase
                if (status !== want_rsp.status)
                    flag_mismatch($sformatf("status %0d, expected %0d", status,
                                            want_rsp.status));
                if (slot !== want_rsp.slot)
                    flag_mismatch($sformatf("slot %0d, expected %0d", slot, want_rsp.slot));
                if (hit_action !== want_rsp.hit_action)
                    flag_mismatch($sformatf("hit_action %0h, expected %0h", hit_action,
                                            want_rsp.hit_action));
            end
        end
    end

    initial
    begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        int seg;
        int i;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed requests
        queue_request(OP_HIT,    32'h0000_0000, 32'h0000_0000, 8'h00);
        queue_request(OP_MODIFY, 32'h0000_0000, 32'h0000_0000, 8'h11);
        queue_request(OP_DELETE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
        queue_request(OP_ADD,    32'h0000_0000, 32'h0000_0000, 8'h00);
        queue_request(OP_ADD,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
        queue_request(OP_ADD,    32'h0000_0000, 32'h1234_5678, 8'h5A);
        queue_request(OP_ADD,    32'h0000_0001, 32'hFFFF_FFFF, 8'hA5);
        queue_request(OP_HIT,    32'h0000_0000, 32'hFFFF_FFFF, 8'h00);
        queue_request(OP_HIT,    32'hFFFF_FFFF, 32'h0000_0000, 8'hFF);
        queue_request(OP_MODIFY, 32'h0000_0000, 32'h0000_0000, 8'h3C);
        queue_request(OP_HIT,    32'h0000_0000, 32'h0000_0000, 8'h00);
        queue_request(OP_DELETE, 32'h0000_0000, 32'h0000_0000, 8'h00);
        queue_request(OP_HIT,    32'h0000_0000, 32'h0000_0000, 8'h00);
        queue_request(OP_MODIFY, 32'h0000_0000, 32'hFFFF_FFFF, 8'hFF);
        queue_request(OP_HIT,    32'h0000_0000, 32'h1234_5678, 8'h00);
        queue_request(OP_DELETE, 32'hFFFF_FFFF, 32'h0000_0000, 8'h00);
        queue_request(OP_HIT,    32'h0000_0000, 32'hFFFF_FFFF, 8'h00);
        queue_request(OP_ADD,    32'h0000_0002, 32'hAAAA_AAAA, 8'h55);
        queue_request(OP_HIT,    32'hAAAA_AAAA, 32'h5555_5555, 8'hAA);
        queue_request(OP_DELETE, 32'h0000_0000, 32'h0000_0000, 8'h00);
        queue_request(OP_DELETE, 32'h0000_0000, 32'h0000_0000, 8'h00);
        queue_request(OP_MODIFY, 32'h0000_0001, 32'h0000_0000, 8'h00);

        for (seg = 0; seg < NUM_SEGS; seg++)
        begin
            wait_quiet();
            case (seg % 4)
                0:       set_idle(0, 0);
                1:       set_idle(61, 0);
                2:       set_idle(0, 61);
                default: set_idle(22, 22);
            endcase
            if (seg == 2)
                holdoff_arm = 1'b1;
            for (i = 0; i < RAND_PER_SEG; i++)
                request_q.push_back(make_request(seg_mix[seg]));
            if (seg == 2)
            begin
                do
                    @(negedge clk);
                while (holdoff_left == 0);
                holdoff_arm = 1'b0;
            end
        end

        wait_quiet();
        repeat (TABLE_ENTRIES + 20) @(negedge clk);

        $display("covered %0d requests: directed corners, fill past full, drain, noise",
                 accepted_cnt);
        $display("%0d results: %0d done or hit, %0d table full, %0d not found or miss",
                 results_seen, done_cnt, full_cnt, miss_cnt);
        if (err_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

/* filelist.f */
rtl/fte_pkg.sv
rtl/fte_cell.sv
rtl/flow_table_match_engine.sv
bench/tb_top.sv
